[hw/rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/tps_pkg.sv]
`timescale 1ns / 1ps
package tps_pkg;

  // field and register widths
  localparam int PTS_W      = 40;
  localparam int DIGITS_W   = 48;
  localparam int LIMIT_W    = 32;
  localparam int NUM_SLOTS  = 12;
  localparam int DELTA_W    = 32;
  localparam int NUM_W      = 5;
  localparam int PROD_W     = DELTA_W + NUM_W;
  localparam int DEN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 6;
  localparam int STEP_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_DIGITS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FIELD_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT         = 2'd3;

  // result frame kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WOVEN = 2'd1;
  localparam logic [1:0] KIND_PROG  = 2'd2;

  // micro-operations
  typedef logic [2:0] uop_t;
  localparam uop_t UOP_ACCEPT  = 3'd0;
  localparam uop_t UOP_FRONT   = 3'd1;
  localparam uop_t UOP_MUL     = 3'd2;
  localparam uop_t UOP_SUM     = 3'd3;
  localparam uop_t UOP_DIVINIT = 3'd4;
  localparam uop_t UOP_DIVSTEP = 3'd5;
  localparam uop_t UOP_EMIT    = 3'd6;
  localparam uop_t UOP_NOP     = 3'd7;

  // jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEVER     = 3'd0;
  localparam cond_t COND_ALWAYS    = 3'd1;
  localparam cond_t COND_NO_INPUT  = 3'd2;
  localparam cond_t COND_LOOP      = 3'd3;
  localparam cond_t COND_EMIT_MORE = 3'd4;

  // step names
  localparam logic [STEP_W-1:0] STEP_ACCEPT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_FRONT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SUM     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIVINIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DIVSTEP = 3'd5;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_TAIL    = 3'd7;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic [CNT_W-1:0]  loop_last;
  } ctrl_word_t;

  // microprogram rom
  function automatic ctrl_word_t ucode_rom(logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_ACCEPT:  w = '{UOP_ACCEPT,  COND_NO_INPUT,  STEP_ACCEPT,  '0};
      STEP_FRONT:   w = '{UOP_FRONT,   COND_NEVER,     STEP_ACCEPT,  '0};
      STEP_MUL:     w = '{UOP_MUL,     COND_NEVER,     STEP_ACCEPT,  '0};
      STEP_SUM:     w = '{UOP_SUM,     COND_LOOP,      STEP_SUM,
                          CNT_W'(NUM_SLOTS - 1)};
      STEP_DIVINIT: w = '{UOP_DIVINIT, COND_NEVER,     STEP_ACCEPT,  '0};
      STEP_DIVSTEP: w = '{UOP_DIVSTEP, COND_LOOP,      STEP_DIVSTEP,
                          CNT_W'(PROD_W - 1)};
      STEP_EMIT:    w = '{UOP_EMIT,    COND_EMIT_MORE, STEP_EMIT,    '0};
      default:      w = '{UOP_NOP,     COND_ALWAYS,    STEP_ACCEPT,  '0};
    endcase
    return w;
  endfunction

  // field count of one digit slot, clamped to nine, zero past the last slot
  function automatic logic [3:0] digit_at(logic [DIGITS_W-1:0] digits, logic [3:0] idx);
    logic [DIGITS_W-1:0] sh;
    logic [3:0]          d;
    sh = digits >> {idx, 2'b00};
    d  = sh[3:0];
    if (idx >= 4'(NUM_SLOTS)) begin
      d = 4'd0;
    end else if (d > 4'd9) begin
      d = 4'd9;
    end
    return d;
  endfunction

endpackage

[hw/rtl/telecine_pulldown_sequencer.sv]
// a frame request taken in the accept step passes the front, multiply, digit sum,
//   divide-init, divide and emit steps, one frame at a time; the 12-step digit sum
//   and the 37-step restoring divide share one microcoded datapath
// a new frame request is taken while the last result still waits in the output register
// reset (rst, synchronous): config registers to their defaults, sequencer state to zero
`timescale 1ns / 1ps
module telecine_pulldown_sequencer #(
  parameter int MAX_PATTERN = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  output logic                            frame_stall,
  input  logic [tps_pkg::PTS_W-1:0]       frame_pts,
  input  logic                            geometry_changed,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      frame_kind,
  output logic                            held_parity,
  output logic                            store_to_buffer,
  output logic [tps_pkg::PTS_W-1:0]       out_pts,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tps_pkg::DIGITS_W-1:0]    cfg_data
);
  import tps_pkg::*;

  // configuration registers
  logic [DIGITS_W-1:0] pattern_digits;
  logic [3:0]          pattern_length;
  logic                first_field_bottom;
  logic [LIMIT_W-1:0]  jump_limit;

  // sequencer state
  logic [3:0]          pattern_position;
  logic                field_held;
  logic                group_first;
  logic [PTS_W-1:0]    last_in_pts;
  logic [PTS_W-1:0]    last_out_pts;
  logic                started;

  // datapath registers
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic [CNT_W-1:0]    cnt;
  logic [PTS_W-1:0]    pts_r;
  logic                geo_r;
  logic [PTS_W:0]      diff;
  logic [DELTA_W-1:0]  delta;
  logic [3:0]          len_r;
  logic [PROD_W-1:0]   prod;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;

  ctrl_word_t          cw;

  // combinational helpers
  logic [3:0]          eff_len;
  logic [NUM_W-1:0]    num;
  logic                resync;
  logic [3:0]          pos_eff;
  logic                held_eff;
  logic [4:0]          pos_inc;
  logic [3:0]          sum_digit;
  logic [DEN_W:0]      trial;
  logic                trial_ge;
  logic                slot_free;
  logic                e_last;
  logic                e_store;
  logic [1:0]          e_kind;
  logic                e_parity;
  logic [3:0]          e_rem;
  logic                e_advance;
  logic [PTS_W-1:0]    pts_adv;
  logic                emit_more;
  logic                jump;

  assign cw          = ucode_rom(step);
  assign frame_stall = (step != STEP_ACCEPT);
  assign cfg_ready   = 1'b1;

  // effective pattern length and timestamp numerator
  always_comb begin
    if (pattern_length == 4'd0) begin
      eff_len = 4'd1;
    end else if ({1'b0, pattern_length} > 5'(MAX_PATTERN)) begin
      eff_len = 4'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
    num = {eff_len, 1'b0};
  end

  // resync decision and pattern position for the current frame
  always_comb begin
    resync   = !started || geo_r || diff[PTS_W] ||
               (diff[PTS_W-1:0] > {{(PTS_W-LIMIT_W){1'b0}}, jump_limit});
    pos_eff  = (resync || (pattern_position >= eff_len)) ? 4'd0 : pattern_position;
    held_eff = resync ? 1'b0 : field_held;
    pos_inc  = {1'b0, pos_eff} + 5'd1;
  end

  // digit sum term and restoring divide step
  always_comb begin
    sum_digit = (cnt[3:0] < eff_len) ? digit_at(pattern_digits, cnt[3:0]) : 4'd0;
    trial     = {rem, prod[PROD_W-1]};
    trial_ge  = (trial >= {1'b0, den});
  end

  // plan of the next result
  always_comb begin
    slot_free = !result_valid || !result_stall;
    if (field_held) begin
      e_kind    = KIND_WOVEN;
      e_parity  = first_field_bottom;
      e_rem     = len_r - 4'd1;
      e_advance = 1'b1;
    end else if (len_r >= 4'd2) begin
      e_kind    = KIND_PROG;
      e_parity  = 1'b0;
      e_rem     = len_r - 4'd2;
      e_advance = 1'b1;
    end else begin
      e_kind    = KIND_NONE;
      e_parity  = 1'b0;
      e_rem     = 4'd1;
      e_advance = 1'b0;
    end
    e_last    = (e_rem < 4'd2);
    e_store   = (e_rem == 4'd1);
    pts_adv   = (group_first || den == '0) ? last_out_pts
              : last_out_pts + {{(PTS_W-PROD_W){1'b0}}, prod};
    emit_more = (len_r != 4'd0) && !(slot_free && e_last);
  end

  // step sequencing
  always_comb begin
    case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !frame_valid;
      COND_LOOP:      jump = (cnt != cw.loop_last);
      COND_EMIT_MORE: jump = emit_more;
      default:        jump = 1'b0;
    endcase
    step_next = jump ? cw.target : step + STEP_W'(1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_digits     <= DIGITS_W'(50);
      pattern_length     <= 4'd2;
      first_field_bottom <= 1'b0;
      jump_limit         <= LIMIT_W'(45000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_DIGITS:     pattern_digits     <= cfg_data;
        CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        CFG_FIRST_FIELD_BOTTOM: first_field_bottom <= cfg_data[0];
        CFG_JUMP_LIMIT:         jump_limit         <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= STEP_ACCEPT;
      cnt              <= '0;
      pattern_position <= 4'd0;
      field_held       <= 1'b0;
      group_first      <= 1'b0;
      last_in_pts      <= '0;
      last_out_pts     <= '0;
      started          <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      step <= step_next;
      // free the output register unless a new result replaces it
      if (result_valid && !result_stall &&
          !(cw.op == UOP_EMIT && len_r != 4'd0)) begin
        result_valid <= 1'b0;
      end
      case (cw.op)
        UOP_FRONT: begin
          started          <= 1'b1;
          field_held       <= held_eff;
          last_in_pts      <= pts_r;
          pattern_position <= (pos_inc >= {1'b0, eff_len}) ? 4'd0 : pos_inc[3:0];
          if (resync || (pos_eff == 4'd0 && !held_eff)) begin
            last_out_pts <= pts_r;
          end
          if (pos_eff == 4'd0 && !held_eff) begin
            group_first <= 1'b1;
          end
        end
        UOP_MUL: begin
          cnt <= '0;
        end
        UOP_SUM, UOP_DIVSTEP: begin
          cnt <= (cnt == cw.loop_last) ? '0 : cnt + CNT_W'(1);
        end
        UOP_EMIT: begin
          if (len_r != 4'd0 && slot_free) begin
            result_valid <= 1'b1;
            field_held   <= e_last && e_store;
            if (e_advance) begin
              group_first  <= 1'b0;
              last_out_pts <= pts_adv;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    case (cw.op)
      UOP_ACCEPT: begin
        if (frame_valid) begin
          pts_r <= frame_pts;
          geo_r <= geometry_changed;
          diff  <= {1'b0, frame_pts} - {1'b0, last_in_pts};
        end
      end
      UOP_FRONT: begin
        len_r <= digit_at(pattern_digits, pos_eff);
        delta <= resync ? '0 : diff[DELTA_W-1:0];
      end
      UOP_MUL: begin
        prod <= PROD_W'(delta) * PROD_W'(num);
        den  <= '0;
      end
      UOP_SUM: begin
        den <= den + DEN_W'(sum_digit);
      end
      UOP_DIVINIT: begin
        rem <= '0;
      end
      UOP_DIVSTEP: begin
        rem  <= trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        prod <= {prod[PROD_W-2:0], trial_ge};
      end
      UOP_EMIT: begin
        if (len_r != 4'd0 && slot_free) begin
          len_r           <= e_last ? 4'd0 : e_rem;
          frame_kind      <= e_kind;
          held_parity     <= e_parity;
          store_to_buffer <= e_last && e_store;
          last            <= e_last;
          out_pts         <= e_advance ? pts_adv : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/tps_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          frame_valid,
  input logic                          frame_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [1:0]                    frame_kind,
  input logic                          held_parity,
  input logic                          store_to_buffer,
  input logic [tps_pkg::PTS_W-1:0]     out_pts,
  input logic                          last
);
  import tps_pkg::*;

  // a stalled result keeps its timestamp
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(out_pts))

  // the block is busy right after taking a frame
  `ASSERT_NEXT(a_busy_after_request, clk, rst, frame_valid && !frame_stall, frame_stall)

  // a store request only marks the final result of a frame
  `ASSERT_SAME(a_store_on_last, clk, rst, result_valid && store_to_buffer, last)

  // a store-only result carries no frame and no timestamp
  `ASSERT_SAME(a_store_only, clk, rst, result_valid && frame_kind == KIND_NONE, store_to_buffer && last && out_pts == '0)

  // held parity appears only on woven frames
  `ASSERT_SAME(a_parity_woven, clk, rst, result_valid && held_parity, frame_kind == KIND_WOVEN)

endmodule

bind telecine_pulldown_sequencer tps_checker u_tps_checker (
  .clk             (clk),
  .rst             (rst),
  .frame_valid     (frame_valid),
  .frame_stall     (frame_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .frame_kind      (frame_kind),
  .held_parity     (held_parity),
  .store_to_buffer (store_to_buffer),
  .out_pts         (out_pts),
  .last            (last)
);
